// ===== src/sha384_pkg.sv =====
// ----------------------------------------------------------------------------
// sha384_pkg
// types, constants and round functions shared by the sha-384 engine
// ----------------------------------------------------------------------------
`default_nettype none

package sha384_pkg;

    typedef struct packed {
        logic [63:0] message_word;
        logic [3:0]  valid_bytes;
        logic        last_word;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        last_of_digest;
    } out_item_t;

    typedef logic [63:0] word_t;

    localparam int unsigned ROUNDS       = 80;
    localparam int unsigned DIGEST_WORDS = 6;
    localparam logic [7:0]  PAD_BYTE     = 8'h80;

    localparam word_t INIT_HASH [8] = '{
        64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
        64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
        64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
    };

    localparam word_t ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic word_t big_sig0(input word_t x);
        return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
    endfunction

    function automatic word_t big_sig1(input word_t x);
        return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
    endfunction

    function automatic word_t small_sig0(input word_t x);
        return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ (x >> 7);
    endfunction

    function automatic word_t small_sig1(input word_t x);
        return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ (x >> 6);
    endfunction

endpackage

`default_nettype wire

// ===== src/sha384_hash_engine_unit.sv =====
// ----------------------------------------------------------------------------
// sha384_hash_engine_unit
// sha-384 over a stream of big-endian 64-bit message words
// ----------------------------------------------------------------------------
// input channel s_*: one message word per transfer, valid bytes packed from
// the msb; last_word closes the message. output channel m_*: six digest
// words per message, most significant first, last_of_digest on the sixth.
// a word that does not fill the 16-word window is shifted in and s_ready
// stays high for the next word. a word that fills it starts one compression:
// pushing it loads the working variables from the hash, then the 80 rounds
// for the 128-byte block run on the single shared round datapath, then the hash is updated.
// after the last word the padding words are pushed one per cycle (plus one
// or two compressions), then the six digest words are presented one per
// cycle. s_ready is low from the last word until the sixth digest word
// has been taken. when the receiver stalls the current digest word holds.
// reset (aresetn low, synchronous) loads the initial hash values and
// clears the byte count and all sequencing state.
// ----------------------------------------------------------------------------
`default_nettype none

module sha384_hash_engine_unit
    import sha384_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PUSH  = 5'b00010,
        S_ROUND = 5'b00100,
        S_ADD   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    word_t       win_reg  [16];
    word_t       win_next [16];
    word_t       hash_reg [8];
    word_t       hash_next[8];
    word_t       var_reg  [8];
    word_t       var_next [8];
    logic [3:0]  slot_reg, slot_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [63:0] total_reg, total_next;
    logic [2:0]  idx_reg, idx_next;
    logic        pad_reg, pad_next;
    logic        extra_reg, extra_next;
    logic        first_reg, first_next;
    logic        done_reg, done_next;

    logic        push_en;
    word_t       push_w;
    word_t       sched_w;
    word_t       t1, t2, ch_v, maj_v;
    logic [3:0]  nb;
    word_t       last_w;

    // last word: keep valid bytes, then the pad byte
    always_comb begin
        nb = (s_data.valid_bytes > 4'd8) ? 4'd8 : s_data.valid_bytes;
        last_w = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < nb) begin
                last_w[63-8*i -: 8] = s_data.message_word[63-8*i -: 8];
            end else if (4'(i) == nb) begin
                last_w[63-8*i -: 8] = PAD_BYTE;
            end
        end
    end

    always_comb begin
        sched_w = small_sig1(win_reg[14]) + win_reg[9] + small_sig0(win_reg[1]) + win_reg[0];
        ch_v    = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        maj_v   = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
                ^ (var_reg[1] & var_reg[2]);
        t1      = var_reg[7] + big_sig1(var_reg[4]) + ch_v + ROUND_K[rnd_reg] + win_reg[0];
        t2      = big_sig0(var_reg[0]) + maj_v;
    end

    always_comb begin
        state_next = state_reg;
        win_next   = win_reg;
        hash_next  = hash_reg;
        var_next   = var_reg;
        slot_next  = slot_reg;
        rnd_next   = rnd_reg;
        total_next = total_reg;
        idx_next   = idx_reg;
        pad_next   = pad_reg;
        extra_next = extra_reg;
        first_next = first_reg;
        done_next  = done_reg;
        push_en    = 1'b0;
        push_w     = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    push_en = 1'b1;
                    if (s_data.last_word) begin
                        total_next = total_reg + 64'(nb);
                        push_w     = (nb == 4'd8) ? s_data.message_word : last_w;
                        pad_next   = 1'b1;
                        extra_next = (nb == 4'd8);
                        first_next = 1'b1;
                    end else begin
                        total_next = total_reg + 64'd8;
                        push_w     = s_data.message_word;
                    end
                end
            end
            S_PUSH: begin
                push_en = 1'b1;
                if (extra_reg) begin
                    push_w     = {PAD_BYTE, 56'd0};
                    extra_next = 1'b0;
                end else if (slot_reg == 4'd15 && !first_reg) begin
                    push_w    = {total_reg[60:0], 3'd0};
                    pad_next  = 1'b0;
                    done_next = 1'b1;
                end else begin
                    push_w     = '0;
                    first_next = 1'b0;
                end
            end
            S_ROUND: begin
                for (int i = 0; i < 15; i++) begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[15] = sched_w;
                var_next[7] = var_reg[6];
                var_next[6] = var_reg[5];
                var_next[5] = var_reg[4];
                var_next[4] = var_reg[3] + t1;
                var_next[3] = var_reg[2];
                var_next[2] = var_reg[1];
                var_next[1] = var_reg[0];
                var_next[0] = t1 + t2;
                if (rnd_reg == 7'(ROUNDS - 1)) begin
                    rnd_next   = '0;
                    state_next = S_ADD;
                end else begin
                    rnd_next = rnd_reg + 7'd1;
                end
            end
            S_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    hash_next[i] = hash_reg[i] + var_reg[i];
                end
                state_next = done_reg ? S_OUT : (pad_reg ? S_PUSH : S_IDLE);
            end
            S_OUT: begin
                if (m_ready) begin
                    if (idx_reg == 3'(DIGEST_WORDS - 1)) begin
                        idx_next   = '0;
                        hash_next  = INIT_HASH;
                        total_next = '0;
                        done_next  = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (push_en) begin
            for (int i = 0; i < 15; i++) begin
                win_next[i] = win_reg[i+1];
            end
            win_next[15] = push_w;
            slot_next    = slot_reg + 4'd1;
            if (slot_reg == 4'd15) begin
                var_next   = hash_reg;
                rnd_next   = '0;
                state_next = S_ROUND;
            end else begin
                state_next = pad_next ? S_PUSH : S_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            hash_reg  <= INIT_HASH;
            slot_reg  <= '0;
            rnd_reg   <= '0;
            total_reg <= '0;
            idx_reg   <= '0;
            pad_reg   <= 1'b0;
            extra_reg <= 1'b0;
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            hash_reg  <= hash_next;
            slot_reg  <= slot_next;
            rnd_reg   <= rnd_next;
            total_reg <= total_next;
            idx_reg   <= idx_next;
            pad_reg   <= pad_next;
            extra_reg <= extra_next;
            first_reg <= first_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        var_reg <= var_next;
    end

    assign s_ready               = (state_reg == S_IDLE);
    assign m_valid               = (state_reg == S_OUT);
    assign m_data.digest_word    = hash_reg[idx_reg];
    assign m_data.word_index     = idx_reg;
    assign m_data.last_of_digest = (idx_reg == 3'(DIGEST_WORDS - 1));

endmodule

`default_nettype wire

// ===== src/sha384_chk.sv =====
// ----------------------------------------------------------------------------
// sha384_chk
// port-level checks on the sha-384 engine, bound to sha384_hash_engine_unit
// ----------------------------------------------------------------------------
`default_nettype none

module sha384_chk
    import sha384_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_item_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    // no input transfer while a digest is being delivered
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready during digest output");

    // last flag marks exactly the sixth word
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_of_digest == (m_data.word_index == 3'd5)))
        else $error("last_of_digest mismatch");

    // digest words step through in order
    a_idx_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last_of_digest)
            |=> (m_valid && m_data.word_index == $past(m_data.word_index) + 3'd1))
        else $error("digest index did not advance");

    // a stalled digest word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("digest word changed under stall");

    // a waiting input word holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_data)))
        else $error("input word changed while waiting");

endmodule

bind sha384_hash_engine_unit sha384_chk u_sha384_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
